// ===== rtl/pipo_pkg.sv =====
// ----------------------------------------------------------------------------
// PIPO-64/128 shared definitions
// Block type, register indexes and the round layer functions.
// ----------------------------------------------------------------------------
package pipo_pkg;

  localparam int unsigned BlockW        = 64;
  localparam int unsigned RowW          = 8;
  localparam int unsigned RowCount      = BlockW / RowW;
  localparam int unsigned RoundCountDef = 13;
  localparam int unsigned CfgIdxW       = 1;

  typedef logic [BlockW-1:0]  block_t;
  typedef logic [RowW-1:0]    row_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_KEY_LO = 1'b0;
  localparam cfg_idx_t REG_KEY_HI = 1'b1;

  function automatic row_t rotl8(row_t v, logic [2:0] amt);
    logic [2*RowW-1:0] w;
    w = {v, v} << amt;
    return w[2*RowW-1:RowW];
  endfunction

  // Bit-sliced S-box: bit j of row i is input bit i of column j.
  function automatic block_t sub_columns(block_t s);
    row_t a [RowCount];
    row_t t0;
    row_t t1;
    row_t t2;
    block_t r;
    for (int i = 0; i < RowCount; i++) begin
      a[i] = s[i*RowW +: RowW];
    end
    a[5] = a[5] ^ (a[7] & a[6]);
    a[4] = a[4] ^ (a[3] & a[5]);
    a[7] = a[7] ^ a[4];
    a[6] = a[6] ^ a[3];
    a[3] = a[3] ^ (a[4] | a[5]);
    a[5] = a[5] ^ a[7];
    a[4] = a[4] ^ (a[5] & a[6]);

    a[2] = a[2] ^ (a[1] & a[0]);
    a[0] = a[0] ^ (a[2] | a[1]);
    a[1] = a[1] ^ (a[2] | a[0]);
    a[2] = ~a[2];

    a[7] = a[7] ^ a[1];
    a[3] = a[3] ^ a[2];
    a[4] = a[4] ^ a[0];

    t0 = a[7];
    t1 = a[3];
    t2 = a[4];
    a[6] = a[6] ^ (t0 & a[5]);
    t0 = t0 ^ a[6];
    a[6] = a[6] ^ (t2 | t1);
    t1 = t1 ^ a[5];
    a[5] = a[5] ^ (a[6] | t2);
    t2 = t2 ^ (t1 & t0);

    a[2] = a[2] ^ t0;
    t0 = a[1] ^ t2;
    a[1] = a[0] ^ t1;
    a[0] = a[7];
    a[7] = t0;
    t1 = a[3];
    a[3] = a[6];
    a[6] = t1;
    t2 = a[4];
    a[4] = a[5];
    a[5] = t2;
    for (int i = 0; i < RowCount; i++) begin
      r[i*RowW +: RowW] = a[i];
    end
    return r;
  endfunction

  function automatic block_t rotate_rows(block_t s);
    block_t r;
    r[0*RowW +: RowW] = s[0*RowW +: RowW];
    r[1*RowW +: RowW] = rotl8(s[1*RowW +: RowW], 3'd7);
    r[2*RowW +: RowW] = rotl8(s[2*RowW +: RowW], 3'd4);
    r[3*RowW +: RowW] = rotl8(s[3*RowW +: RowW], 3'd3);
    r[4*RowW +: RowW] = rotl8(s[4*RowW +: RowW], 3'd6);
    r[5*RowW +: RowW] = rotl8(s[5*RowW +: RowW], 3'd5);
    r[6*RowW +: RowW] = rotl8(s[6*RowW +: RowW], 3'd1);
    r[7*RowW +: RowW] = rotl8(s[7*RowW +: RowW], 3'd2);
    return r;
  endfunction

endpackage

// ===== rtl/pipo_round.sv =====
// ----------------------------------------------------------------------------
// PIPO round stage
// One registered round: S-layer, row rotation, round key and round constant addition.
// ----------------------------------------------------------------------------
module pipo_round #(
  parameter int unsigned RoundIdx = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  pipo_pkg::block_t state_i,
  input  pipo_pkg::block_t key_lo_i,
  input  pipo_pkg::block_t key_hi_i,
  output logic             valid_o,
  output pipo_pkg::block_t state_o
);
  import pipo_pkg::*;

  localparam row_t RoundConst = row_t'(RoundIdx);

  logic   valid_q;
  block_t state_d;
  block_t state_q;
  block_t round_key;

  assign round_key = (RoundIdx % 2 == 1) ? key_hi_i : key_lo_i;
  assign state_d   = rotate_rows(sub_columns(state_i)) ^ round_key
                     ^ {{(BlockW-RowW){1'b0}}, RoundConst};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      state_q <= state_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;

endmodule

// ===== rtl/spn_64bit_block_encrypt.sv =====
// ----------------------------------------------------------------------------
// PIPO-64/128 block encryption pipeline
// Whitening stage followed by one register stage per round.
// ----------------------------------------------------------------------------
//   Port group        Direction  Beat marked by
//   start/plain_block in         start_i while busy_o is low
//   done/cipher_block out        done_o, one cycle, cannot be held off
//   cfg               in         cfg_we_i
//
// A block passes from start to done through one whitening register and one
// register per round, each round being one S-layer.
// A new block is taken every cycle and busy_o stays low.
// Reset clears the valid bits and both key halves.
// ----------------------------------------------------------------------------
module spn_64bit_block_encrypt #(
  parameter int unsigned ROUND_COUNT = pipo_pkg::RoundCountDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  pipo_pkg::block_t   plain_block_i,
  output logic               done_o,
  output pipo_pkg::block_t   cipher_block_o,
  input  logic               cfg_we_i,
  input  pipo_pkg::cfg_idx_t cfg_idx_i,
  input  pipo_pkg::block_t   cfg_wdata_i
);
  import pipo_pkg::*;

  block_t key_lo_q;
  block_t key_hi_q;
  logic   stage_valid [ROUND_COUNT+1];
  block_t stage_blk   [ROUND_COUNT+1];
  logic   white_valid_q;
  block_t white_blk_q;
  logic   accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q <= '0;
      key_hi_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KEY_LO: key_lo_q <= cfg_wdata_i;
        REG_KEY_HI: key_hi_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      white_valid_q <= 1'b0;
    end else begin
      white_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      white_blk_q <= plain_block_i ^ key_lo_q;
    end
  end

  assign stage_valid[0] = white_valid_q;
  assign stage_blk[0]   = white_blk_q;

  for (genvar r = 1; r <= ROUND_COUNT; r++) begin : g_round
    pipo_round #(
      .RoundIdx(r)
    ) u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stage_valid[r-1]),
      .state_i (stage_blk[r-1]),
      .key_lo_i(key_lo_q),
      .key_hi_i(key_hi_q),
      .valid_o (stage_valid[r]),
      .state_o (stage_blk[r])
    );
  end

  assign done_o         = stage_valid[ROUND_COUNT];
  assign cipher_block_o = stage_blk[ROUND_COUNT];

`ifndef NO_ASSERTIONS
  a_beat_leaves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    white_valid_q |-> ##ROUND_COUNT done_o)
    else $error("whitened block did not reach the output");

  a_no_ghost : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !white_valid_q |-> ##ROUND_COUNT !done_o)
    else $error("output strobe without a matching input beat");

  a_accept_whiten : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> white_valid_q)
    else $error("accepted beat did not enter the whitening stage");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PIPO-64/128 encryption pipeline testbench
// Loads key halves between phases while the pipeline is empty, sends
// directed and random plaintext blocks with random idle cycles, and
// checks every ciphertext against an in-bench model of the cipher.
// ----------------------------------------------------------------------------
module tb_top;

  import pipo_pkg::*;

  localparam int unsigned RoundsUsed = RoundCountDef;
  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned DrainGap   = RoundCountDef + 8;
  localparam int RowRot [RowCount]   = '{0, 7, 4, 3, 6, 5, 1, 2};

  logic     clk_i;
  logic     rst_ni;
  logic     start_i;
  logic     busy_o;
  block_t   plain_block_i;
  logic     done_o;
  block_t   cipher_block_o;
  logic     cfg_we_i;
  cfg_idx_t cfg_idx_i;
  block_t   cfg_wdata_i;

  block_t      plain_q [$];
  block_t      cipher_q [$];
  block_t      key_lo_m = '0;
  block_t      key_hi_m = '0;
  logic        beat_taken = 1'b0;
  int unsigned idle_pct = 9;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;

  spn_64bit_block_encrypt u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .plain_block_i (plain_block_i),
    .done_o        (done_o),
    .cipher_block_o(cipher_block_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic row_t rot_left(row_t b, int n);
    return row_t'((b << n) | (b >> (RowW - n)));
  endfunction

  // Each bit lane across the eight rows is one S-box input; row i is bit i.
  function automatic block_t sbox_columns(block_t s);
    row_t r [RowCount];
    row_t u;
    row_t v;
    row_t w;
    block_t o;
    for (int i = 0; i < RowCount; i++) r[i] = s[i*RowW +: RowW];
    r[5] ^= r[7] & r[6];
    r[4] ^= r[3] & r[5];
    r[7] ^= r[4];
    r[6] ^= r[3];
    r[3] ^= r[4] | r[5];
    r[5] ^= r[7];
    r[4] ^= r[5] & r[6];
    r[2] ^= r[1] & r[0];
    r[0] ^= r[2] | r[1];
    r[1] ^= r[2] | r[0];
    r[2] = ~r[2];
    r[7] ^= r[1];
    r[3] ^= r[2];
    r[4] ^= r[0];
    u = r[7];
    v = r[3];
    w = r[4];
    r[6] ^= u & r[5];
    u ^= r[6];
    r[6] ^= w | v;
    v ^= r[5];
    r[5] ^= r[6] | w;
    w ^= v & u;
    r[2] ^= u;
    o[0*RowW +: RowW] = r[7];
    o[1*RowW +: RowW] = r[0] ^ v;
    o[2*RowW +: RowW] = r[2];
    o[3*RowW +: RowW] = r[6];
    o[4*RowW +: RowW] = r[5];
    o[5*RowW +: RowW] = r[4];
    o[6*RowW +: RowW] = r[3];
    o[7*RowW +: RowW] = r[1] ^ w;
    return o;
  endfunction

  function automatic block_t encrypt_block(block_t p, block_t k_lo, block_t k_hi);
    block_t x;
    x = p ^ k_lo;
    for (int rnd = 1; rnd <= RoundsUsed; rnd++) begin
      x = sbox_columns(x);
      for (int i = 1; i < RowCount; i++) begin
        x[i*RowW +: RowW] = rot_left(x[i*RowW +: RowW], RowRot[i]);
      end
      x ^= (rnd % 2 == 1) ? k_hi : k_lo;
      x[RowW-1:0] ^= row_t'(rnd);
    end
    return x;
  endfunction

  task automatic report_mismatch(string what, block_t got, block_t want);
    $display("mismatch at %0t: %s got %016h expected %016h", $time, what, got, want);
    err_cnt++;
  endtask

  task automatic write_reg(cfg_idx_t idx, block_t data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic load_block(block_t b);
    @(posedge clk_i);
    plain_q.push_back(b);
  endtask

  task automatic load_random(int unsigned n);
    @(posedge clk_i);
    for (int unsigned i = 0; i < n; i++) begin
      plain_q.push_back({$urandom, $urandom});
    end
  endtask

  // The sender stays quiet until every outstanding ciphertext has come back.
  task automatic drain;
    while (plain_q.size() != 0 || start_i) @(posedge clk_i);
    while (cipher_q.size() != 0) @(posedge clk_i);
    repeat (DrainGap) @(negedge clk_i);
  endtask

  task automatic load_directed;
    load_block('0);
    load_block('1);
    load_block(64'h5555_5555_5555_5555);
    load_block(64'hAAAA_AAAA_AAAA_AAAA);
    load_block(64'h0000_0000_0000_0001);
    load_block(64'h8000_0000_0000_0000);
    load_block(64'h0123_4567_89AB_CDEF);
    load_block(64'hFEDC_BA98_7654_3210);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && (!start_i || beat_taken)) begin
      if (plain_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start_i       <= 1'b1;
        plain_block_i <= plain_q.pop_front();
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    block_t want;
    beat_taken <= rst_ni && start_i && !busy_o;
    if (rst_ni && start_i && !busy_o) begin
      cipher_q.push_back(encrypt_block(plain_block_i, key_lo_m, key_hi_m));
    end
    if (rst_ni && cfg_we_i) begin
      case (cfg_idx_i)
        REG_KEY_LO: key_lo_m <= cfg_wdata_i;
        REG_KEY_HI: key_hi_m <= cfg_wdata_i;
        default: ;
      endcase
    end
    if (rst_ni && done_o) begin
      if (cipher_q.size() == 0) begin
        report_mismatch("unexpected beat", cipher_block_o, '0);
      end else begin
        want = cipher_q.pop_front();
        if (cipher_block_o !== want) report_mismatch("cipher_block", cipher_block_o, want);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    plain_block_i = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_KEY_LO;
    cfg_wdata_i   = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    load_directed();
    drain();

    write_reg(REG_KEY_LO, '1);
    write_reg(REG_KEY_HI, '1);
    load_directed();
    drain();

    load_random(100);
    drain();

    write_reg(REG_KEY_LO, '1);
    write_reg(REG_KEY_HI, '0);
    load_random(100);
    drain();

    write_reg(REG_KEY_LO, '0);
    write_reg(REG_KEY_HI, '1);
    load_random(100);
    drain();

    idle_pct = 0;
    write_reg(REG_KEY_LO, {$urandom, $urandom});
    write_reg(REG_KEY_HI, {$urandom, $urandom});
    load_random(100);
    drain();

    idle_pct = 9;
    write_reg(REG_KEY_HI, {$urandom, $urandom});
    write_reg(REG_KEY_LO, {$urandom, $urandom});
    load_random(50);
    drain();
    load_random(50);
    drain();

    if (err_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
